@@ hw/rtl/pgfd_pkg.sv @@
// Shared widths, constants, codes and types of the field-difference Prewitt gradient block.
package pgfd_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLS    = 4096;
    localparam int SAMPLE_BITS = 16;

    // 3x3 window; also the smallest legal grid dimension
    localparam int WIN_SIZE = 3;
    localparam int WIN_CELLS = WIN_SIZE * WIN_SIZE;

    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int ROWS_W    = $clog2(MAX_ROWS + 1);
    localparam int COLS_W    = $clog2(MAX_COLS + 1);

    // z = void - solid, one bit wider than a sample
    localparam int Z_W    = SAMPLE_BITS + 1;
    // sum of three differences of z
    localparam int SUM_W  = Z_W + 3;
    // magnitude of a sum, and the quotient width after dividing by three
    localparam int MAG_W  = SUM_W - 1;
    localparam int GRAD_W = SUM_W - 2;

    // reciprocal of three, scaled by 2**SUM_W and rounded up; exact for magnitudes below 2**MAG_W
    localparam int DIV3_SHIFT = SUM_W;
    localparam logic [MAG_W-1:0] DIV3_RECIP = MAG_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (ROWS_W > COLS_W) ? ROWS_W : COLS_W;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = CFG_IDX_W'(1);

    localparam logic [ROWS_W-1:0] ROWS_MIN   = ROWS_W'(WIN_SIZE);
    localparam logic [ROWS_W-1:0] ROWS_MAX   = ROWS_W'(MAX_ROWS);
    localparam logic [COLS_W-1:0] COLS_MIN   = COLS_W'(WIN_SIZE);
    localparam logic [COLS_W-1:0] COLS_MAX   = COLS_W'(MAX_COLS);

    // column buffer word: {z of column c-1, z of column c-2}
    localparam int COLBUF_W = 2 * Z_W;

    typedef logic signed [Z_W-1:0]   zval_t;
    typedef logic signed [SUM_W-1:0] gsum_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row;
        logic [COL_IDX_W-1:0] col;
        logic                 last;
    } point_meta_t;

endpackage

@@ hw/rtl/pgfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pgfd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/pgfd_div3.sv @@
// Signed divide by three, truncating toward zero, by reciprocal multiplication.
module pgfd_div3 (
    input  logic signed [pgfd_pkg::SUM_W-1:0]  num,
    output logic signed [pgfd_pkg::GRAD_W-1:0] quot
);
    import pgfd_pkg::*;

    logic                   neg;
    logic [MAG_W-1:0]       mag;
    logic [2*MAG_W-1:0]     prod;
    logic [GRAD_W-2:0]      q;

    always_comb
    begin
        neg  = num[SUM_W-1];
        mag  = neg ? MAG_W'(-num) : MAG_W'(num);
        prod = mag * DIV3_RECIP;
        q    = prod[DIV3_SHIFT +: (GRAD_W-1)];
        quot = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

endmodule

@@ hw/rtl/prewitt_gradient_of_field_difference.sv @@
// Top level: streamed Prewitt gradient of (void - solid) over a column-major grid.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------------
//  sample   | sample_valid / sample_stall| solid_dist, void_dist (signed Q11.4)
//  grad     | grad_valid / grad_stall    | grad_x, grad_y, center_row, center_col, last_point
//  cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One sample is taken every cycle unless sample_stall is raised; an interior point's result
// passes the p1, p2, p3 and output registers after the sample at (row+1, col+1) is taken.
// The rate is set by the single column-buffer RAM, read and written back once per sample.
// Reset clears the counters, the window and pipeline valids and loads the default grid size;
// the column buffer is not cleared, since no result ever reads an entry before it is written.
// A stalled result holds the output register; samples keep flowing into empty stages behind it.
module prewitt_gradient_of_field_difference (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // sample channel
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [pgfd_pkg::SAMPLE_BITS-1:0] solid_dist,
    input  logic signed [pgfd_pkg::SAMPLE_BITS-1:0] void_dist,
    // result channel
    output logic                                    grad_valid,
    input  logic                                    grad_stall,
    output logic signed [pgfd_pkg::GRAD_W-1:0]      grad_x,
    output logic signed [pgfd_pkg::GRAD_W-1:0]      grad_y,
    output logic        [pgfd_pkg::ROW_IDX_W-1:0]   center_row,
    output logic        [pgfd_pkg::COL_IDX_W-1:0]   center_col,
    output logic                                    last_point,
    // configuration channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [pgfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [pgfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pgfd_pkg::*;

    // ------------------------------------------------------------------
    // configuration and scan counters
    // ------------------------------------------------------------------
    logic [ROWS_W-1:0]    grid_rows_reg, grid_rows_next;
    logic [COLS_W-1:0]    grid_cols_reg, grid_cols_next;
    logic [ROW_IDX_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_IDX_W-1:0] col_cnt_reg, col_cnt_next;
    logic                 cfg_hit;
    logic [ROWS_W-1:0]    cfg_rows;
    logic [COLS_W-1:0]    cfg_cols;

    // ------------------------------------------------------------------
    // pipeline: p1 = RAM read in flight, p2 = window, p3 = sums, out
    // ------------------------------------------------------------------
    logic        p1_valid_reg, p2_valid_reg, p3_valid_reg, grad_valid_reg;
    logic        out_free, p3_free, p2_free, p1_free;
    logic        p3_move, p2_move, p1_move;
    logic        accept;

    zval_t                p1_z_reg;
    logic [ROW_IDX_W-1:0] p1_addr_reg;
    logic                 p1_emit_reg;
    point_meta_t          p1_meta_reg;

    zval_t                win_reg [WIN_CELLS];
    zval_t                win_next [WIN_CELLS];
    point_meta_t          p2_meta_reg;

    gsum_t                sx_reg, sy_reg, sx_next, sy_next;
    point_meta_t          p3_meta_reg;

    logic signed [GRAD_W-1:0] grad_x_reg, grad_y_reg, qx, qy;
    point_meta_t              out_meta_reg;

    // accept-side decode of the current scan position
    zval_t                z_in;
    logic                 emit_in;
    logic [ROWS_W-1:0]    row_inc;
    logic [COLS_W-1:0]    col_inc;
    logic                 row_wrap, col_wrap;
    point_meta_t          meta_in;

    // column buffer
    logic [COLBUF_W-1:0]  rd_word;
    zval_t                old_v, new_v;

    // ------------------------------------------------------------------
    // configuration decode: clamp to the legal range, restart the frame
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_rows  = cfg_data[ROWS_W-1:0];
    assign cfg_cols  = cfg_data[COLS_W-1:0];

    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        cfg_hit        = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRID_ROWS:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_rows < ROWS_MIN)
                        grid_rows_next = ROWS_MIN;
                    else if (cfg_rows > ROWS_MAX)
                        grid_rows_next = ROWS_MAX;
                    else
                        grid_rows_next = cfg_rows;
                end
                CFG_GRID_COLS:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_cols < COLS_MIN)
                        grid_cols_next = COLS_MIN;
                    else if (cfg_cols > COLS_MAX)
                        grid_cols_next = COLS_MAX;
                    else
                        grid_cols_next = cfg_cols;
                end
                default:
                begin
                    // unknown index: ignore the write
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: a stage takes a new item when empty or when it drains
    // ------------------------------------------------------------------
    assign out_free = !grad_valid_reg || !grad_stall;
    assign p3_free  = !p3_valid_reg || out_free;
    assign p2_free  = !p2_valid_reg || p3_free;
    assign p1_free  = !p1_valid_reg || p2_free;
    assign p3_move  = p3_valid_reg && out_free;
    assign p2_move  = p2_valid_reg && p3_free;
    assign p1_move  = p1_valid_reg && p2_free;

    assign sample_stall = !p1_free;
    assign accept       = sample_valid && p1_free;

    // ------------------------------------------------------------------
    // accept side: z, scan position, result bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        z_in     = zval_t'(void_dist) - zval_t'(solid_dist);
        row_inc  = ROWS_W'(row_cnt_reg) + ROWS_W'(1);
        col_inc  = COLS_W'(col_cnt_reg) + COLS_W'(1);
        row_wrap = (row_inc >= grid_rows_reg);
        col_wrap = (col_inc >= grid_cols_reg);
        // the window is complete once two earlier rows and columns are in
        emit_in  = (row_cnt_reg >= ROW_IDX_W'(WIN_SIZE - 1))
                && (col_cnt_reg >= COL_IDX_W'(WIN_SIZE - 1));
        meta_in.row  = row_cnt_reg - ROW_IDX_W'(1);
        meta_in.col  = col_cnt_reg - COL_IDX_W'(1);
        meta_in.last = row_wrap && col_wrap;

        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (cfg_hit)
        begin
            // a register write restarts the frame
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (accept)
        begin
            if (row_wrap)
            begin
                row_cnt_next = '0;
                col_cnt_next = col_wrap ? '0 : col_inc[COL_IDX_W-1:0];
            end
            else
            begin
                row_cnt_next = row_inc[ROW_IDX_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // column buffer: read on accept, write back {z, c-1 value} as p1 drains
    // ------------------------------------------------------------------
    pgfd_ram #(
        .WIDTH (COLBUF_W),
        .DEPTH (MAX_ROWS)
    ) u_colbuf (
        .clk     (clk),
        .wr_en   (p1_move),
        .wr_addr (p1_addr_reg),
        .wr_data ({p1_z_reg, new_v}),
        .rd_en   (accept),
        .rd_addr (row_cnt_reg),
        .rd_data (rd_word)
    );

    assign new_v = rd_word[COLBUF_W-1:Z_W];
    assign old_v = rd_word[Z_W-1:0];

    // shift the window up one row; new bottom row is {c-2, c-1, c}
    always_comb
    begin
        for (int i = 0; i < WIN_CELLS - WIN_SIZE; i++)
        begin
            win_next[i] = win_reg[i + WIN_SIZE];
        end
        win_next[WIN_CELLS-3] = old_v;
        win_next[WIN_CELLS-2] = new_v;
        win_next[WIN_CELLS-1] = p1_z_reg;
    end

    // sums of right-minus-left and bottom-minus-top over the window
    always_comb
    begin
        sx_next = '0;
        sy_next = '0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            sx_next = sx_next + gsum_t'(win_reg[WIN_SIZE*i + WIN_SIZE - 1])
                              - gsum_t'(win_reg[WIN_SIZE*i]);
            sy_next = sy_next + gsum_t'(win_reg[WIN_SIZE*(WIN_SIZE-1) + i])
                              - gsum_t'(win_reg[i]);
        end
    end

    pgfd_div3 u_div3_x (
        .num  (sx_reg),
        .quot (qx)
    );

    pgfd_div3 u_div3_y (
        .num  (sy_reg),
        .quot (qy)
    );

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg  <= ROWS_MAX;
            grid_cols_reg  <= COLS_MAX;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            grad_valid_reg <= 1'b0;
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            if (p1_free)
                p1_valid_reg <= accept;
            // border samples drop out here after updating the window
            if (p2_free)
                p2_valid_reg <= p1_move && p1_emit_reg;
            if (p3_free)
                p3_valid_reg <= p2_move;
            if (out_free)
                grad_valid_reg <= p3_move;
        end
    end

    // window state: cleared by reset, advanced once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_CELLS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (p1_move)
        begin
            for (int i = 0; i < WIN_CELLS; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_z_reg    <= z_in;
            p1_addr_reg <= row_cnt_reg;
            p1_emit_reg <= emit_in;
            p1_meta_reg <= meta_in;
        end
        if (p1_move)
        begin
            p2_meta_reg <= p1_meta_reg;
        end
        if (p2_move)
        begin
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            p3_meta_reg <= p2_meta_reg;
        end
        if (p3_move)
        begin
            grad_x_reg   <= qx;
            grad_y_reg   <= qy;
            out_meta_reg <= p3_meta_reg;
        end
    end

    assign grad_valid = grad_valid_reg;
    assign grad_x     = grad_x_reg;
    assign grad_y     = grad_y_reg;
    assign center_row = out_meta_reg.row;
    assign center_col = out_meta_reg.col;
    assign last_point = out_meta_reg.last;

`ifndef SYNTHESIS
    // the input only backs up when the RAM stage is occupied
    a_stall_needs_p1: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> p1_valid_reg)
        else $error("sample_stall raised with the read stage empty");

    // scan position stays inside the configured grid
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ROWS_W'(row_cnt_reg) < grid_rows_reg) && (COLS_W'(col_cnt_reg) < grid_cols_reg))
        else $error("scan counter outside the configured grid");

    // a register write restarts the frame
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == CFG_GRID_ROWS || cfg_index == CFG_GRID_COLS))
        |=> (row_cnt_reg == '0) && (col_cnt_reg == '0))
        else $error("frame not restarted after a register write");

    // a result only leaves for a point away from the border
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(grad_valid_reg) |-> (out_meta_reg.row != '0) && (out_meta_reg.col != '0))
        else $error("result issued for a border point");
`endif

endmodule

@@ tb/prewitt_gradient_of_field_difference_test.sv @@
// Self-checking testbench for the streamed Prewitt gradient of the void-minus-solid field.
`timescale 1ns / 100ps

module prewitt_gradient_of_field_difference_test;
    import pgfd_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 12;
    // give items that carry no result room to retire from the pipeline
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_CYCLES  = 2000;
    localparam int RANDOM_ITEMS     = 340;
    localparam int TALL_ITEMS       = 40;
    localparam int PRESSURE_DIM     = 8;
    localparam int REPORT_LIMIT     = 10;
    localparam int ROWS_HIGH_BITS   = CFG_DATA_W - ROWS_W;

    // indexes past the register list; a write there must leave the frame alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] solid_d;
        logic signed [SAMPLE_BITS-1:0] void_d;
    } field_sample_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [ROW_IDX_W-1:0]     row;
        logic [COL_IDX_W-1:0]     col;
        logic                     last_pt;
    } grad_point_t;

    // ------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic signed [SAMPLE_BITS-1:0] solid_dist   = '0;
    logic signed [SAMPLE_BITS-1:0] void_dist    = '0;
    logic                          grad_valid;
    logic                          grad_stall   = 1'b0;
    logic signed [GRAD_W-1:0]      grad_x;
    logic signed [GRAD_W-1:0]      grad_y;
    logic [ROW_IDX_W-1:0]          center_row;
    logic [COL_IDX_W-1:0]          center_col;
    logic                          last_point;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;

    prewitt_gradient_of_field_difference u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .solid_dist   (solid_dist),
        .void_dist    (void_dist),
        .grad_valid   (grad_valid),
        .grad_stall   (grad_stall),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .center_row   (center_row),
        .center_col   (center_col),
        .last_point   (last_point),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the grid geometry, both column
    // buffers, the 3x3 window and the raster position.
    // ------------------------------------------------------------------
    int    field_rows = MAX_ROWS;
    int    field_cols = MAX_COLS;
    int    row_pos    = 0;
    int    col_pos    = 0;
    zval_t older_z [MAX_ROWS] = '{default: '0};
    zval_t newer_z [MAX_ROWS] = '{default: '0};
    // index 3*row + col; row 2 and col 2 hold the newest values
    zval_t window_z [WIN_CELLS] = '{default: '0};

    field_sample_t samples_to_send [$];
    grad_point_t   pending_gradients [$];
    int            samples_queued = 0;
    int            samples_taken  = 0;
    int            mismatches     = 0;

    function automatic int clamp_dim(input int value, input int lo, input int hi);
        return (value < lo) ? lo : ((value > hi) ? hi : value);
    endfunction

    // A register write restarts the frame; buffers and window keep their contents.
    function automatic void update_geometry(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_GRID_ROWS || idx == CFG_GRID_COLS)
        begin
            if (idx == CFG_GRID_ROWS)
                field_rows = clamp_dim(int'(data[ROWS_W-1:0]), WIN_SIZE, MAX_ROWS);
            else
                field_cols = clamp_dim(int'(data[COLS_W-1:0]), WIN_SIZE, MAX_COLS);
            row_pos = 0;
            col_pos = 0;
        end
    endfunction

    // Push one sample through the line buffers and window; queue a gradient
    // when the window is centered on an interior point.
    function automatic void advance_field(input logic signed [SAMPLE_BITS-1:0] solid_s,
                                          input logic signed [SAMPLE_BITS-1:0] void_s);
        zval_t       z;
        zval_t       old_z;
        zval_t       new_z;
        gsum_t       sum_x;
        gsum_t       sum_y;
        grad_point_t pt;

        z     = void_s - solid_s;
        old_z = older_z[row_pos];
        new_z = newer_z[row_pos];
        older_z[row_pos] = new_z;
        newer_z[row_pos] = z;

        for (int i = 0; i < WIN_CELLS - WIN_SIZE; i++)
            window_z[i] = window_z[i + WIN_SIZE];
        window_z[6] = old_z;
        window_z[7] = new_z;
        window_z[8] = z;

        if (row_pos >= 2 && col_pos >= 2)
        begin
            sum_x = '0;
            sum_y = '0;
            for (int i = 0; i < WIN_SIZE; i++)
            begin
                sum_x += window_z[3 * i + 2] - window_z[3 * i];
                sum_y += window_z[6 + i] - window_z[i];
            end
            // signed division truncates toward zero
            pt.gx      = GRAD_W'(sum_x / 3);
            pt.gy      = GRAD_W'(sum_y / 3);
            pt.row     = ROW_IDX_W'(row_pos - 1);
            pt.col     = COL_IDX_W'(col_pos - 1);
            pt.last_pt = (row_pos + 1 >= field_rows) && (col_pos + 1 >= field_cols);
            pending_gradients = {pending_gradients, pt};
        end

        row_pos++;
        if (row_pos >= field_rows)
        begin
            row_pos = 0;
            col_pos++;
            if (col_pos >= field_cols)
                col_pos = 0;
        end
    endfunction

    function automatic void check_gradient();
        grad_point_t got;
        grad_point_t want;

        got = '{grad_x, grad_y, center_row, center_col, last_point};
        if (pending_gradients.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result with none expected: gx=%0d gy=%0d row=%0d col=%0d last=%0b",
                         $time, got.gx, got.gy, got.row, got.col, got.last_pt);
        end
        else
        begin
            want = pending_gradients.pop_front();
            if (got.gx !== want.gx || got.gy !== want.gy || got.row !== want.row ||
                got.col !== want.col || got.last_pt !== want.last_pt)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: mismatch, expected gx=%0d gy=%0d row=%0d col=%0d last=%0b",
                             $time, want.gx, want.gy, want.row, want.col, want.last_pt);
                    $display("%0t: mismatch, got      gx=%0d gy=%0d row=%0d col=%0d last=%0b",
                             $time, got.gx, got.gy, got.row, got.col, got.last_pt);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted sample, check every accepted result.
    // Values are read at the edge, before the DUT's own updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            advance_field(solid_dist, void_dist);
            samples_taken++;
        end
        if (rst_n && grad_valid && !grad_stall)
            check_gradient();
    end

    // ------------------------------------------------------------------
    // Driver: send queued samples in bursts of random length separated by
    // random gaps. A stalled item stays put until it is taken.
    // ------------------------------------------------------------------
    field_sample_t next_sample;
    int            send_burst = 1;
    int            send_gap   = 0;

    always @(posedge clk)
    begin
        if (!sample_valid || !sample_stall)
        begin
            if (send_gap != 0)
            begin
                sample_valid <= 1'b0;
                send_gap--;
            end
            else if (samples_to_send.size() != 0)
            begin
                next_sample = samples_to_send.pop_front();
                sample_valid <= 1'b1;
                solid_dist   <= next_sample.solid_d;
                void_dist    <= next_sample.void_d;
                if (send_burst > 1)
                    send_burst--;
                else
                begin
                    // one burst in three runs straight into the next one
                    send_burst = $urandom_range(1, 48);
                    send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result-side stall: switch between free flow, random stalls and a
    // periodic pattern; a long hold can be armed to back the pipe up.
    // ------------------------------------------------------------------
    stall_mode_t stall_mode      = STALL_NONE;
    int          stall_span      = 0;
    int          stall_tick      = 0;
    int          long_hold_left  = 0;
    bit          long_hold_armed = 1'b0;

    always @(posedge clk)
    begin
        if (long_hold_armed)
        begin
            long_hold_armed = 1'b0;
            long_hold_left  = LONG_HOLD_CYCLES;
        end
        if (long_hold_left != 0)
        begin
            grad_stall <= 1'b1;
            long_hold_left--;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 2));
                stall_span = $urandom_range(16, 160);
            end
            else
                stall_span--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:   grad_stall <= 1'b0;
                STALL_RANDOM: grad_stall <= ($urandom_range(0, 2) == 0);
                default:      grad_stall <= (stall_tick % 5) < 2;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on any channel for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (grad_valid && !grad_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("[prewitt_gradient_of_field_difference] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register; the predictor takes the write at the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        update_geometry(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued item is taken and every result is back,
    // then let result-free items drain out of the pipe.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (samples_taken != samples_queued || pending_gradients.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] solid_s,
                                input logic signed [SAMPLE_BITS-1:0] void_s);
        field_sample_t item;

        item.solid_d    = solid_s;
        item.void_d     = void_s;
        samples_to_send = {samples_to_send, item};
        samples_queued++;
    endtask

    // Mix full-scale extremes, small values near zero and uniform noise.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return SAMPLE_BITS'(int'($urandom_range(0, 63)) - 32);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_sample(pick_sample(), pick_sample());
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] rows_data;
    logic [CFG_DATA_W-1:0] cols_data;
    int                    frame_len;
    int                    burst_items;
    int                    first_part;
    int                    random_sent;

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest grid, reached through values below the legal range.
        write_reg(CFG_GRID_ROWS, CFG_DATA_W'(0));
        write_reg(CFG_GRID_COLS, CFG_DATA_W'(2));

        // Full-scale positive column gradient: left column at the floor of z,
        // right column at its ceiling.
        for (int c = 0; c < WIN_SIZE; c++)
            for (int r = 0; r < WIN_SIZE; r++)
                case (c)
                    0:       queue_sample(SAMPLE_MAX, SAMPLE_MIN);
                    1:       queue_sample('0, '0);
                    default: queue_sample(SAMPLE_MIN, SAMPLE_MAX);
                endcase
        // Frame wrapped; full-scale negative row gradient next.
        for (int c = 0; c < WIN_SIZE; c++)
            for (int r = 0; r < WIN_SIZE; r++)
                case (r)
                    0:       queue_sample(SAMPLE_MIN, SAMPLE_MAX);
                    1:       queue_sample('0, '0);
                    default: queue_sample(SAMPLE_MAX, SAMPLE_MIN);
                endcase
        // Small values exercise truncation toward zero; the frame is left
        // unfinished so the next register write has to restart it.
        for (int i = 0; i < 7; i++)
            queue_sample(SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4),
                         SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4));
        wait_idle();

        // Tallest grid, reached by clamping an oversized value; part of the first column.
        write_reg(CFG_GRID_ROWS, {CFG_DATA_W{1'b1}});
        write_reg(CFG_GRID_COLS, CFG_DATA_W'(WIN_SIZE));
        queue_random(TALL_ITEMS);
        wait_idle();

        // One full mid-size frame. Hold the result side off early so the
        // pipe fills and stalls its input.
        write_reg(CFG_GRID_ROWS, CFG_DATA_W'(PRESSURE_DIM));
        write_reg(CFG_GRID_COLS, CFG_DATA_W'(PRESSURE_DIM));
        queue_random(field_rows * field_cols);
        long_hold_armed = 1'b1;
        wait_idle();

        // Exact upper limits; too short to reach an interior point.
        write_reg(CFG_GRID_ROWS, CFG_DATA_W'(MAX_ROWS));
        write_reg(CFG_GRID_COLS, CFG_DATA_W'(MAX_COLS));
        queue_random(20);
        wait_idle();

        // Three rows with ignored upper bits in the data; widest grid.
        write_reg(CFG_GRID_ROWS, {ROWS_HIGH_BITS'('1), ROWS_W'(WIN_SIZE)});
        queue_random(60);
        wait_idle();
        // Writes past the register list must not restart the frame.
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom()));
        queue_random(30);
        wait_idle();
        write_reg(CFG_GRID_COLS, {CFG_DATA_W{1'b1}});
        queue_random(45);
        wait_idle();
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
        queue_random(25);
        wait_idle();

        // Random part: mostly whole frames of small grids, some cut short.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       rows_data = CFG_DATA_W'($urandom_range(0, 2));
                1:       rows_data = {ROWS_HIGH_BITS'($urandom_range(1, 3)),
                                      ROWS_W'($urandom_range(3, 12))};
                2:       rows_data = CFG_DATA_W'($urandom_range(13, 40));
                default: rows_data = CFG_DATA_W'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 11))
                0:       cols_data = CFG_DATA_W'($urandom_range(0, 2));
                1:       cols_data = CFG_DATA_W'($urandom_range(MAX_COLS + 1, 8191));
                default: cols_data = CFG_DATA_W'($urandom_range(3, 8));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(CFG_GRID_ROWS, rows_data);
                write_reg(CFG_GRID_COLS, cols_data);
            end
            else
            begin
                write_reg(CFG_GRID_COLS, cols_data);
                write_reg(CFG_GRID_ROWS, rows_data);
            end

            frame_len = field_rows * field_cols;
            if (frame_len > 400 || $urandom_range(0, 4) == 0)
                burst_items = $urandom_range(1, (frame_len > 120) ? 120 : frame_len);
            else
                burst_items = frame_len * $urandom_range(1, 2);
            // keep the total close to the planned item count
            if (burst_items > RANDOM_ITEMS - random_sent)
                burst_items = RANDOM_ITEMS - random_sent;

            if (random_sent == 0)
                long_hold_armed = 1'b1;

            if ($urandom_range(0, 5) == 0 && burst_items > 1)
            begin
                // split the run with an ignored write in the middle
                first_part = $urandom_range(1, burst_items - 1);
                queue_random(first_part);
                wait_idle();
                write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          CFG_DATA_W'($urandom()));
                queue_random(burst_items - first_part);
            end
            else
                queue_random(burst_items);
            random_sent += burst_items;
            wait_idle();
        end

        if (pending_gradients.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_gradients.size());
            mismatches += pending_gradients.size();
        end

        if (mismatches == 0)
            $display("[prewitt_gradient_of_field_difference] OK");
        else
            $display("[prewitt_gradient_of_field_difference] ERROR");
        $finish;
    end

endmodule
